/* hw/rtl/gbdi_pkg.sv */
`default_nettype none

package gbdi_pkg;

  // calibration and accumulator sizing
  localparam int unsigned SKIP_SAMPLES = 256;
  localparam int unsigned AVG_LOG2     = 8;
  localparam int unsigned ANGLE_BITS   = 48;

  localparam int unsigned CAL_TOTAL = SKIP_SAMPLES + (1 << AVG_LOG2);
  localparam int unsigned CNT_W     = $clog2(CAL_TOTAL + 1);
  localparam int unsigned SUM_W     = 17 + AVG_LOG2;

  // field widths
  localparam int unsigned RATE_W = 16;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned DB_W   = 15;
  localparam int unsigned OP_W   = 2;

  localparam logic [DB_W-1:0] DEADBAND_RST = DB_W'(82);

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_RESTART = 2'd1,
    OP_LOAD    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // per-lane control from the calibration sequencer
  typedef struct packed {
    logic sample;
    logic sum_en;
    logic finish;
    logic clear;
  } lane_ctrl_t;

  // one result as held in the output buffer
  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic signed [OUT_W-1:0]  angle_x;
    logic signed [OUT_W-1:0]  angle_y;
    logic signed [OUT_W-1:0]  angle_z;
    logic                     calibrated;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/gyro_bias_deadband_integrator.sv */
// Gyro bias removal, deadband and angle integration.
// Input channel (in_valid_i / in_stall_o): each request carries op_i and three
// raw gyro rates plus an x angle load value. op 0 is a sample, op 1 restarts
// bias calibration, op 2 loads the x angle, op 3 does nothing.
// Output channel (out_valid_o / out_stall_i): exactly one result per request,
// in order: corrected and deadbanded rates (zero for non-sample requests),
// the three angle accumulators after the request and the calibrated flag.
// Three identical axis lanes work in parallel; their results are merged into
// a two-entry output buffer, registered, so out_valid_o rises the cycle after
// acceptance; throughput is one request per cycle while in_stall_o is low.
// in_stall_o rises only when both buffer entries hold unread results, so a
// stalling receiver costs nothing until two results are waiting.
// Write the deadband register through deadband_we_i / deadband_i only while
// the block is idle; the block does not enforce this. It resets to 82.
// Reset clears bias, angles and the calibrated flag and starts calibration:
// 256 samples are skipped and the next 256 are averaged into the new bias.
`default_nettype none

module gyro_bias_deadband_integrator
  import gbdi_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     deadband_we_i,
  input  wire logic [DB_W-1:0]          deadband_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [OP_W-1:0]          op_i,
  input  wire logic signed [RATE_W-1:0] gyro_x_i,
  input  wire logic signed [RATE_W-1:0] gyro_y_i,
  input  wire logic signed [RATE_W-1:0] gyro_z_i,
  input  wire logic signed [OUT_W-1:0]  angle_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [RATE_W-1:0]      rate_x_o,
  output logic signed [RATE_W-1:0]      rate_y_o,
  output logic signed [RATE_W-1:0]      rate_z_o,
  output logic signed [OUT_W-1:0]       angle_x_o,
  output logic signed [OUT_W-1:0]       angle_y_o,
  output logic signed [OUT_W-1:0]       angle_z_o,
  output logic                          calibrated_o
);

  logic [DB_W-1:0] deadband_q;
  logic            full;
  logic            accept;
  lane_ctrl_t      ctrl;
  logic            load;
  logic            cal_done;
  res_t            res_new;
  res_t            res_out;

  // deadband register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
    end else if (deadband_we_i) begin
      deadband_q <= deadband_i;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // calibration sequencer and request decode
  gbdi_cal u_cal (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_e'(op_i)),
    .ctrl_o     (ctrl),
    .load_o     (load),
    .cal_done_o (cal_done)
  );

  // axis lanes
  gbdi_lane u_lane_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .load_i       (load),
    .load_value_i (angle_value_i),
    .deadband_i   (deadband_q),
    .raw_i        (gyro_x_i),
    .rate_o       (res_new.rate_x),
    .angle_o      (res_new.angle_x)
  );

  gbdi_lane u_lane_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .load_i       (1'b0),
    .load_value_i (angle_value_i),
    .deadband_i   (deadband_q),
    .raw_i        (gyro_y_i),
    .rate_o       (res_new.rate_y),
    .angle_o      (res_new.angle_y)
  );

  gbdi_lane u_lane_z (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .load_i       (1'b0),
    .load_value_i (angle_value_i),
    .deadband_i   (deadband_q),
    .raw_i        (gyro_z_i),
    .rate_o       (res_new.rate_z),
    .angle_o      (res_new.angle_z)
  );

  assign res_new.calibrated = cal_done;

  // merge lane results into the output buffer
  gbdi_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res_new),
    .out_stall_i (out_stall_i),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign rate_x_o     = res_out.rate_x;
  assign rate_y_o     = res_out.rate_y;
  assign rate_z_o     = res_out.rate_z;
  assign angle_x_o    = res_out.angle_x;
  assign angle_y_o    = res_out.angle_y;
  assign angle_z_o    = res_out.angle_z;
  assign calibrated_o = res_out.calibrated;

endmodule

`default_nettype wire

/* hw/rtl/gbdi_lane.sv */
`default_nettype none

module gbdi_lane
  import gbdi_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lane_ctrl_t               ctrl_i,
  input  wire logic                     load_i,
  input  wire logic signed [OUT_W-1:0]  load_value_i,
  input  wire logic [DB_W-1:0]          deadband_i,
  input  wire logic signed [RATE_W-1:0] raw_i,
  output logic signed [RATE_W-1:0]      rate_o,
  output logic signed [OUT_W-1:0]       angle_o
);

  logic signed [RATE_W-1:0]     bias_q, bias_d;
  logic signed [SUM_W-1:0]      sum_q, sum_d;
  logic signed [ANGLE_BITS-1:0] acc_q, acc_d;

  logic signed [RATE_W-1:0]     corr;
  logic        [RATE_W-1:0]     mag;
  logic signed [RATE_W-1:0]     rate;
  logic signed [SUM_W-1:0]      sum_rnd;
  logic signed [63:0]           load_wide;
  logic signed [63:0]           acc_wide;

  // bias correction and deadband
  always_comb begin
    corr = raw_i - bias_q;
    mag  = corr[RATE_W-1] ? RATE_W'(-corr) : corr;
    rate = (mag < {1'b0, deadband_i}) ? '0 : corr;
  end

  assign rate_o = ctrl_i.sample ? rate : '0;

  // calibration sum and truncating average
  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.sum_en) begin
      sum_d = sum_q + SUM_W'(raw_i);
    end
    sum_rnd = sum_d[SUM_W-1] ? sum_d + SUM_W'((1 << AVG_LOG2) - 1) : sum_d;
    bias_d  = ctrl_i.finish ? sum_rnd[AVG_LOG2 +: RATE_W] : bias_q;
  end

  // angle accumulator, wraps at its own width
  always_comb begin
    load_wide = 64'(load_value_i);
    acc_d     = acc_q;
    if (ctrl_i.sample) begin
      acc_d = acc_q + ANGLE_BITS'(rate);
    end else if (load_i) begin
      acc_d = load_wide[ANGLE_BITS-1:0];
    end
    acc_wide = 64'(acc_d);
  end

  assign angle_o = acc_wide[OUT_W-1:0];

  // lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      sum_q  <= '0;
      acc_q  <= '0;
    end else begin
      bias_q <= bias_d;
      sum_q  <= sum_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gbdi_cal.sv */
`default_nettype none

module gbdi_cal
  import gbdi_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  wire op_e   op_i,
  output lane_ctrl_t ctrl_o,
  output logic       load_o,
  output logic       cal_done_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q, done_d;
  logic             running;

  assign running = count_q < CNT_W'(CAL_TOTAL);

  // decode the request and step the calibration count
  always_comb begin
    ctrl_o  = '0;
    load_o  = 1'b0;
    count_d = count_q;
    done_d  = done_q;
    if (accept_i) begin
      case (op_i)
        OP_SAMPLE: begin
          ctrl_o.sample = 1'b1;
          if (running) begin
            ctrl_o.sum_en = count_q >= CNT_W'(SKIP_SAMPLES);
            count_d       = count_q + CNT_W'(1);
            if (count_q == CNT_W'(CAL_TOTAL - 1)) begin
              ctrl_o.finish = 1'b1;
              done_d        = 1'b1;
            end
          end
        end
        OP_RESTART: begin
          ctrl_o.clear = 1'b1;
          count_d      = '0;
        end
        OP_LOAD: begin
          load_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign cal_done_o = done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gbdi_merge.sv */
`default_nettype none

module gbdi_merge
  import gbdi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  input  wire logic out_stall_i,
  output logic      full_o,
  output logic      out_valid_o,
  output res_t      res_o
);

  logic [1:0] count_q, count_d;
  res_t       slot0_q, slot0_d;
  res_t       slot1_q, slot1_d;
  logic       pop;

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign out_valid_o = count_q != 2'd0;
  assign full_o      = count_q == 2'd2;
  assign res_o       = slot0_q;

  // two-entry result buffer, head always in slot0
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    count_d = count_q + 2'(push_i) - 2'(pop);
    case (count_q)
      2'd0: begin
        if (push_i) slot0_d = res_i;
      end
      2'd1: begin
        if (push_i && pop) begin
          slot0_d = res_i;
        end else if (push_i) begin
          slot1_d = res_i;
        end
      end
      2'd2: begin
        if (pop) slot0_d = slot1_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/gbdi_checker.sv */
`default_nettype none

module gbdi_checker
  import gbdi_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic signed [RATE_W-1:0] rate_x_o,
  input wire logic signed [OUT_W-1:0]  angle_x_o,
  input wire logic                     calibrated_o
);

  logic [2:0] pend_q;
  logic       seen_cal_q;

  // requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      seen_cal_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 3'(in_valid_i && !in_stall_o) - 3'(out_valid_o && !out_stall_i);
      if (out_valid_o && !out_stall_i && calibrated_o) seen_cal_q <= 1'b1;
    end
  end

  // a result is shown exactly when one is owed
  a_valid_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o == (pend_q != 3'd0))
    else $error("out_valid_o does not match outstanding requests");

  // never more than two results held
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("more results outstanding than buffer depth");

  // calibrated flag never drops once delivered
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seen_cal_q) |-> calibrated_o)
    else $error("calibrated flag dropped");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(rate_x_o) && $stable(angle_x_o)))
    else $error("stalled result changed");

endmodule

bind gyro_bias_deadband_integrator gbdi_checker u_gbdi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .rate_x_o     (rate_x_o),
  .angle_x_o    (angle_x_o),
  .calibrated_o (calibrated_o)
);

`default_nettype wire
